@@ sv/aesctr_pkg.sv @@
// Shared types, constants and byte functions of the AES-128 CTR stream unit.
// Used by aesctr_round and aes128_ctr_stream_unit; depends on nothing.
`default_nettype none
package aesctr_pkg;

   typedef struct packed {
      logic [7:0] data_in;
      logic       first_of_message;
      logic       last_of_message;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } rsp_type;

   // byte 0 of a block sits in element 15 (most significant)
   typedef logic [15:0][7:0] block_type;

   localparam int unsigned CsrIdxW   = 3;
   localparam int unsigned NumRounds = 10;

   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW      = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_COUNTER_HIGH = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_COUNTER_LOW  = 3'd3;

   localparam logic [7:0] SBOX [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] RCON [1:10] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

endpackage
`default_nettype wire

@@ sv/aesctr_round.sv @@
// One AES-128 round plus the matching key schedule step, combinational.
// Shared by all ten rounds; uses aesctr_pkg for the S-box, RCON and xtime.
`default_nettype none
module aesctr_round (
   input  wire aesctr_pkg::block_type state_in,
   input  wire aesctr_pkg::block_type rkey_in,
   input  wire [7:0]                  rcon,
   input  wire                        last_round,
   output aesctr_pkg::block_type      state_out,
   output aesctr_pkg::block_type      rkey_out
);
   import aesctr_pkg::*;

   logic [3:0][31:0] w_in, w_out;
   logic [31:0]      t;
   logic [7:0]       s [16];
   logic [7:0]       sh [16];
   logic [7:0]       m [16];
   logic [7:0]       x;

   // word c of a block is bits [127-32c -: 32]
   assign w_in = rkey_in;

   always_comb begin
      // rotate and substitute the last word of the previous round key
      t = {SBOX[w_in[0][23:16]], SBOX[w_in[0][15:8]], SBOX[w_in[0][7:0]],
           SBOX[w_in[0][31:24]]} ^ {rcon, 24'h0};
      w_out[3] = w_in[3] ^ t;
      w_out[2] = w_in[2] ^ w_out[3];
      w_out[1] = w_in[1] ^ w_out[2];
      w_out[0] = w_in[0] ^ w_out[1];
   end

   assign rkey_out = w_out;

   always_comb begin
      x = 8'h00;
      for (int i = 0; i < 16; i++) begin
         s[i] = SBOX[state_in[15-i]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sh[4*c+r] = s[4*((c+r)%4)+r];
         end
      end
      for (int c = 0; c < 4; c++) begin
         x = sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3];
         m[4*c]   = sh[4*c]   ^ x ^ xtime(sh[4*c]   ^ sh[4*c+1]);
         m[4*c+1] = sh[4*c+1] ^ x ^ xtime(sh[4*c+1] ^ sh[4*c+2]);
         m[4*c+2] = sh[4*c+2] ^ x ^ xtime(sh[4*c+2] ^ sh[4*c+3]);
         m[4*c+3] = sh[4*c+3] ^ x ^ xtime(sh[4*c+3] ^ sh[4*c]);
      end
      for (int i = 0; i < 16; i++) begin
         // skip MixColumns in the final round
         state_out[15-i] = (last_round ? sh[i] : m[i]) ^ rkey_out[15-i];
      end
   end

endmodule
`default_nettype wire

@@ sv/aes128_ctr_stream_unit.sv @@
// Top level of the AES-128 CTR byte stream: registers, sequencer, output stage.
// Instantiates aesctr_round; uses aesctr_pkg.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_payload (data, first, last)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_payload (data, last)
//   csr     | in        | csr_we                 | csr_index, csr_wdata (64 bits)
//
// A byte at block position 1..15 is answered directly from the keystream register. A
// byte at position zero (or with first set) starts a keystream block: one round a cycle
// through the shared round unit for all ten rounds, then the output register is loaded.
// The round keys are derived round by round from the key registers.
// Reset (synchronous) clears the counter, position and control; the keystream
// register holds garbage until the first block. A stalled rsp holds the output register;
// req_ready drops while it is full and not being taken, and while a block is formed.
`default_nettype none
module aes128_ctr_stream_unit (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire aesctr_pkg::req_type         req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output aesctr_pkg::rsp_type              rsp_payload,
   input  wire                              csr_we,
   input  wire [aesctr_pkg::CsrIdxW-1:0]    csr_index,
   input  wire [63:0]                       csr_wdata
);
   import aesctr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ROUND = 3'b010,
      S_DONE  = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [127:0] key_ff, ctr_cfg_ff, ctr_ff, ctr_in;
   block_type    st_ff, st_in, rk_ff, rk_in, ks_ff, ks_in, st_next, rk_next;
   logic [3:0]   rnd_ff, rnd_in, pos_ff, pos_in, eff_pos;
   logic [7:0]   data_ff, data_in;
   logic         last_ff, last_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic         accept, slot_free, need_block;
   logic [127:0] blk;

   aesctr_round u_round (
      .state_in   (st_ff),
      .rkey_in    (rk_ff),
      .rcon       (RCON[rnd_ff]),
      .last_round (rnd_ff == 4'(NumRounds)),
      .state_out  (st_next),
      .rkey_out   (rk_next)
   );

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_valid && req_ready;
   assign eff_pos    = req_payload.first_of_message ? 4'd0 : pos_ff;
   assign need_block = (eff_pos == 4'd0);
   assign blk        = req_payload.first_of_message ? ctr_cfg_ff : ctr_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         ctr_cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_HIGH:     key_ff[127:64]     <= csr_wdata;
            CSR_KEY_LOW:      key_ff[63:0]       <= csr_wdata;
            CSR_COUNTER_HIGH: ctr_cfg_ff[127:64] <= csr_wdata;
            CSR_COUNTER_LOW:  ctr_cfg_ff[63:0]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctr_in       = ctr_ff;
      pos_in       = pos_ff;
      st_in        = st_ff;
      rk_in        = rk_ff;
      ks_in        = ks_ff;
      rnd_in       = rnd_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in = eff_pos + 4'd1;
               if (need_block) begin
                  // start a keystream block, advance the counter
                  st_in    = blk ^ key_ff;
                  rk_in    = key_ff;
                  rnd_in   = 4'd1;
                  ctr_in   = blk + 128'd1;
                  data_in  = req_payload.data_in;
                  last_in  = req_payload.last_of_message;
                  state_in = S_ROUND;
               end else begin
                  rsp_in.data_out = req_payload.data_in ^ ks_ff[~eff_pos];
                  rsp_in.last_out = req_payload.last_of_message;
                  rsp_valid_in    = 1'b1;
               end
            end
         end
         S_ROUND: begin
            st_in  = st_next;
            rk_in  = rk_next;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'(NumRounds)) begin
               ks_in    = st_next;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_in.data_out = data_ff ^ ks_ff[15];
               rsp_in.last_out = last_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctr_ff       <= '0;
         pos_ff       <= '0;
         rnd_ff       <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff   <= st_in;
      rk_ff   <= rk_in;
      ks_ff   <= ks_in;
      data_ff <= data_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND |-> rnd_ff >= 4'd1 && rnd_ff <= 4'(NumRounds))
      else $error("round count out of range");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND && rnd_ff == 4'(NumRounds) |=> state_ff == S_DONE)
      else $error("block did not finish after the last round");

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      accept && need_block |=> state_ff == S_ROUND && rnd_ff == 4'd1 && pos_ff == 4'd1)
      else $error("keystream block did not start");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("output register changed while stalled");

endmodule
`default_nettype wire

@@ test/tb_aes128_ctr_stream_unit.sv @@
// Testbench of the AES-128 CTR byte stream unit: directed and random byte streams,
// checked against an in-bench AES-128 CTR predictor. Depends on aesctr_pkg and the DUT.
`timescale 1ns / 100ps
`default_nettype none
module tb_aes128_ctr_stream_unit;
   import aesctr_pkg::*;

   localparam int unsigned IdleLimit = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   aes128_ctr_stream_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [63:0] key_hi, key_lo, ctr_hi, ctr_lo;
   logic [127:0] ctr_work;
   logic [7:0] kstream [16];
   logic [3:0] byte_pos;
   rsp_type cipher_q[$];
   int unsigned err_count = 0;
   int unsigned idle_cycles = 0;

   localparam logic [7:0] RoundConst [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                              8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   function automatic logic [7:0] gmul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // s[i] is byte i of the block (column-major, FIPS-197 order)
   function automatic void encrypt_block128(input logic [127:0] key, input logic [127:0] pt,
                                            output logic [7:0] ct [16]);
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0] s [16];
      logic [7:0] u [16];
      logic [7:0] a0, a1, a2, a3, x;
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
            t[31:24] ^= RoundConst[i/4-1];
         end
         w[i] = w[i-4] ^ t;
      end
      for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
         for (int c = 0; c < 4; c++)
            for (int k = 0; k < 4; k++) u[4*c+k] = s[4*((c+k)%4)+k];
         s = u;
         if (r != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               x = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
               s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
               s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
               s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= w[4*r+i/4][31-8*(i%4) -: 8];
      end
      ct = s;
   endfunction

   function automatic void predict_cipher(input req_type it);
      rsp_type r;
      if (it.first_of_message) begin
         ctr_work = {ctr_hi, ctr_lo};
         byte_pos = '0;
      end
      if (byte_pos == 0) begin
         encrypt_block128({key_hi, key_lo}, ctr_work, kstream);
         ctr_work = ctr_work + 128'd1;
      end
      r.data_out = it.data_in ^ kstream[byte_pos];
      r.last_out = it.last_of_message;
      cipher_q = {cipher_q, r};
      byte_pos = byte_pos + 4'd1;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // result checker with random stall
   initial begin
      int unsigned hold;
      rsp_type want;
      @(posedge clock iff !reset);
      forever begin
         hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock iff rsp_valid);
         if (cipher_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_payload.data_out, 'x);
         end else begin
            want = cipher_q.pop_front();
            if (rsp_payload.data_out !== want.data_out)
               report_mismatch("data_out", rsp_payload.data_out, want.data_out);
            if (rsp_payload.last_out !== want.last_out)
               report_mismatch("last_out", rsp_payload.last_out, want.last_out);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high across back-to-back items; drop it only before a gap
   task automatic send_byte(input logic [7:0] data, input logic first, input logic last,
                            input bit no_gap = 0);
      int unsigned gap;
      req_type it;
      gap = no_gap ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.data_in = data;
      it.first_of_message = first;
      it.last_of_message = last;
      req_valid <= 1'b1;
      req_payload <= it;
      @(posedge clock iff req_ready);
      predict_cipher(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (cipher_q.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_KEY_HIGH: key_hi = val;
         CSR_KEY_LOW: key_lo = val;
         CSR_COUNTER_HIGH: ctr_hi = val;
         CSR_COUNTER_LOW: ctr_lo = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [63:0] kh, kl, ch, cl);
      write_reg(CSR_KEY_HIGH, kh);
      write_reg(CSR_KEY_LOW, kl);
      write_reg(CSR_COUNTER_HIGH, ch);
      write_reg(CSR_COUNTER_LOW, cl);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // FIPS-197 appendix key, zero and all-ones extremes, first flag, last flag
   task automatic test_directed();
      write_all(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h55, 1'b0, 1'b1);
      send_byte(8'haa, 1'b1, 1'b1);
      drain();
      write_all('1, '1, '1, '1);
      for (int i = 0; i < 18; i++) send_byte(i[7:0] ^ 8'hc3, i == 0, i == 17);
      drain();
   endtask

   // all-ones counter wraps to zero; counter write takes effect only at first flag
   task automatic test_counter_wrap();
      write_reg(CSR_COUNTER_HIGH, '1);
      write_reg(CSR_COUNTER_LOW, '1);
      for (int i = 0; i < 33; i++) send_byte(8'($urandom), i == 0, i == 32, 1);
      drain();
      write_reg(CSR_COUNTER_LOW, 64'h1);
      for (int i = 0; i < 5; i++) send_byte(8'($urandom), 1'b0, 1'b0);
      drain();
   endtask

   // key write mid-block keeps the formed keystream; unknown index is ignored
   task automatic test_key_change();
      send_byte(8'h12, 1'b1, 1'b0);
      drain();
      write_reg(CSR_KEY_LOW, 64'h0);
      write_reg(3'd5, rand64());
      write_reg(3'd7, '1);
      for (int i = 0; i < 20; i++) send_byte(8'($urandom), 1'b0, 1'b0);
      drain();
   endtask

   task automatic test_random();
      int unsigned sent, len;
      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 5) write_all('0, '0, '0, '0);
         else write_all(rand64(), rand64(), rand64(),
                        phase == 1 ? 64'hffffffffffffffff : rand64());
         if (phase == 1) write_reg(CSR_COUNTER_HIGH, rand64());
         while (sent < 300 * (phase + 1)) begin
            len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 60) : $urandom_range(1, 40);
            if ($urandom_range(0, 9) == 0) begin
               // broken message: no first flag, random last flags
               for (int i = 0; i < len; i++)
                  send_byte(8'($urandom), 1'b0, 1'($urandom));
            end else begin
               for (int i = 0; i < len; i++)
                  send_byte(8'($urandom), i == 0, i == len - 1, $urandom_range(0, 2) == 0);
            end
            sent += len;
         end
         drain();
      end
   endtask

   initial begin
      {key_hi, key_lo, ctr_hi, ctr_lo} = '0;
      ctr_work = '0;
      byte_pos = '0;
      for (int i = 0; i < 16; i++) kstream[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_counter_wrap();
      test_key_change();
      test_random();
      wait (cipher_q.size() == 0);
      repeat (30) @(posedge clock);
      if (err_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
sv/aesctr_pkg.sv
sv/aesctr_round.sv
sv/aes128_ctr_stream_unit.sv
test/tb_aes128_ctr_stream_unit.sv
